// ===== hdl/tawf_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt angle filter package
// Shared widths, register codes, word types and control bundle for the
// accelerometer angle filter.
// ----------------------------------------------------------------------------
package tawf_pkg;

  // Field and register widths.
  localparam int AccelW     = 16;
  localparam int GainW      = 16;
  localparam int OffsetW    = 20;
  localparam int AngleW     = 24;
  localparam int CfgDataW   = 20;
  localparam int CfgIndexW  = 1;

  // Gain fraction bits (Q4.12) and the shift that undoes the tap weights.
  localparam int GainFracW   = 12;
  localparam int WeightShift = 4;

  // The full product of a signed sample and an unsigned gain.
  localparam int ProdW = AccelW + GainW + 1;

  // Weighted sums carry four extra bits for the total weight of sixteen.
  localparam int SumW = AngleW + WeightShift;

  // History ring length.
  localparam int HistDepth = 8;

  // Register reset values.
  localparam logic [GainW-1:0]          GainReset   = 16'd37590;
  localparam logic signed [OffsetW-1:0] OffsetReset = '0;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexW-1:0] {
    RegGain   = 1'b0,
    RegOffset = 1'b1
  } tawf_reg_t;

  // One input word: an accelerometer sample.
  typedef struct packed {
    logic signed [AccelW-1:0] accel_x;
    logic signed [AccelW-1:0] accel_y;
  } tawf_sample_t;

  // One output word: the filtered angles.
  typedef struct packed {
    logic signed [AngleW-1:0] pan_angle;
    logic signed [AngleW-1:0] tilt_angle;
  } tawf_result_t;

  // Stage enables handed to each axis filter.
  typedef struct packed {
    logic shift;
    logic sum;
    logic fin;
  } tawf_ctrl_t;

endpackage

// ===== hdl/tawf_scale.sv =====
// ----------------------------------------------------------------------------
// Axis scaler
// Turns one acceleration into an angle: floor(accel * gain / 2^12) + offset.
// ----------------------------------------------------------------------------
module tawf_scale import tawf_pkg::*; (
  input  logic signed [AccelW-1:0]  accel,
  input  logic        [GainW-1:0]   gain,
  input  logic signed [OffsetW-1:0] offset,
  output logic signed [AngleW-1:0]  angle
);

  logic signed [ProdW-1:0]           prod;
  logic signed [ProdW-GainFracW-1:0] scaled;

  // The gain is unsigned, so it gets a zero sign bit before the multiply.
  assign prod = ProdW'(accel) * $signed({1'b0, gain});

  // Dropping the low bits of a two's complement value rounds toward minus
  // infinity, as the angle definition needs.
  assign scaled = prod[ProdW-1:GainFracW];

  assign angle = AngleW'(scaled) + AngleW'(offset);

endmodule

// ===== hdl/tawf_axis_filter.sv =====
// ----------------------------------------------------------------------------
// Axis history filter
// Eight-tap history line for one angle, with a registered weighted sum.
// ----------------------------------------------------------------------------
module tawf_axis_filter import tawf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  tawf_ctrl_t               ctrl,
  input  logic signed [AngleW-1:0] angle,
  output logic signed [AngleW-1:0] filtered
);

  logic signed [AngleW-1:0] taps [HistDepth];
  logic signed [SumW-1:0]   ext  [HistDepth];
  logic signed [SumW-1:0]   part_new;
  logic signed [SumW-1:0]   part_old;
  logic signed [SumW-1:0]   part_new_next;
  logic signed [SumW-1:0]   part_old_next;
  logic signed [SumW-1:0]   total;

  // History line, newest angle at tap zero; cleared to zero angles at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HistDepth; i++) begin
        taps[i] <= '0;
      end
    end else if (ctrl.shift) begin
      taps[0] <= angle;
      for (int i = 1; i < HistDepth; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  // Sign-extend every tap to the sum width.
  always_comb begin
    for (int i = 0; i < HistDepth; i++) begin
      ext[i] = SumW'(taps[i]);
    end
  end

  // Newest two weigh four, the next two weigh two, the oldest four weigh one.
  assign part_new_next = ((ext[0] + ext[1]) <<< 2) + ((ext[2] + ext[3]) <<< 1);
  assign part_old_next = (ext[4] + ext[5]) + (ext[6] + ext[7]);

  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      part_new <= part_new_next;
      part_old <= part_old_next;
    end
  end

  // Final add; taking the upper bits is the arithmetic shift by four.
  assign total = part_new + part_old;

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      filtered <= total[SumW-1:WeightShift];
    end
  end

endmodule

// ===== hdl/tilt_angle_weighted_fir_unit.sv =====
// ----------------------------------------------------------------------------
// Tilt and pan angle filter
// Scales accelerometer words to angles and smooths each with a weighted
// eight-tap average.
// ----------------------------------------------------------------------------
// A sample is first held in the input word register. Throughput: one word per
// cycle while result_stall is low; the scale multiply and the history shift
// share one pipeline stage, and each level of the tap sum takes one more.
// Reset clears the pipeline valid bits, the history to zero angles, the gain
// to 37590 and the offset to zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module tilt_angle_weighted_fir_unit import tawf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  tawf_sample_t         sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output tawf_result_t         result
);

  logic [GainW-1:0]          gain;
  logic signed [OffsetW-1:0] offset;
  tawf_sample_t              held;
  logic                      held_valid;
  logic                      hist_valid;
  logic                      part_valid;
  logic                      adv_in;
  logic                      adv_hist;
  logic                      adv_part;
  logic                      adv_out;
  tawf_ctrl_t                ctrl;
  logic signed [AngleW-1:0]  pan_raw;
  logic signed [AngleW-1:0]  tilt_raw;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= GainReset;
      offset <= OffsetReset;
    end else if (cfg_write) begin
      unique case (tawf_reg_t'(cfg_index))
        RegGain:   gain   <= cfg_data[GainW-1:0];
        RegOffset: offset <= $signed(cfg_data[OffsetW-1:0]);
        default: ;
      endcase
    end
  end

  // Each stage moves on when it is empty or the stage after it moves.
  assign adv_out  = !result_valid || !result_stall;
  assign adv_part = !part_valid || adv_out;
  assign adv_hist = !hist_valid || adv_part;
  assign adv_in   = !held_valid || adv_hist;

  assign sample_stall = !adv_in;

  assign ctrl.shift = held_valid && adv_hist;
  assign ctrl.sum   = hist_valid && adv_part;
  assign ctrl.fin   = part_valid && adv_out;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      hist_valid   <= 1'b0;
      part_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv_in) begin
        held_valid <= sample_valid;
      end
      if (adv_hist) begin
        hist_valid <= held_valid;
      end
      if (adv_part) begin
        part_valid <= hist_valid;
      end
      if (adv_out) begin
        result_valid <= part_valid;
      end
    end
  end

  // Input word register.
  always_ff @(posedge clk) begin
    if (adv_in) begin
      held <= sample;
    end
  end

  // Y drives pan and x drives tilt.
  tawf_scale u_scale_pan (
    .accel  (held.accel_y),
    .gain   (gain),
    .offset (offset),
    .angle  (pan_raw)
  );

  tawf_scale u_scale_tilt (
    .accel  (held.accel_x),
    .gain   (gain),
    .offset (offset),
    .angle  (tilt_raw)
  );

  tawf_axis_filter u_filter_pan (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .angle    (pan_raw),
    .filtered (result.pan_angle)
  );

  tawf_axis_filter u_filter_tilt (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .angle    (tilt_raw),
    .filtered (result.tilt_angle)
  );

  // Input stalls only when every stage holds a word and the output waits.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (held_valid && hist_valid && part_valid && result_valid))
    else $error("input stalled with an empty stage");

  // A new result word comes only from a filled partial-sum stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(part_valid))
    else $error("result word appeared without a partial sum");

  // The history moves only with a held sample.
  a_shift_word: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift |-> held_valid)
    else $error("history shifted without a sample");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !held_valid && !hist_valid && !part_valid))
    else $error("pipeline not empty after reset");

endmodule
